[rtl/psl_pkg.sv]
// psl_pkg: shared types and command codes for the positional sequence list unit
// no dependencies; used by positional_sequence_list_unit
package psl_pkg;

    localparam logic [2:0] CMD_SEARCH = 3'd0;
    localparam logic [2:0] CMD_GET    = 3'd1;
    localparam logic [2:0] CMD_LOCATE = 3'd2;
    localparam logic [2:0] CMD_SET    = 3'd3;
    localparam logic [2:0] CMD_INSERT = 3'd4;
    localparam logic [2:0] CMD_REMOVE = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_TAKE,
        S_SHIFT
    } state_t;

endpackage

[rtl/positional_sequence_list_unit.sv]
// positional_sequence_list_unit: ordered list of signed 32-bit entries held in one
// synchronous ram (one write port, one registered read port); depends on psl_pkg
// locate, set and rejected commands finish in S_IDLE; get finishes in S_TAKE; search
//   runs in S_SCAN; insert and remove shift entries in S_SHIFT via the one ram read port
// throughput: one transaction at a time, next start taken the cycle busy drops
// done marks each result for one cycle, no stall; async active-low reset clears count
module positional_sequence_list_unit #(
    parameter int CAPACITY = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         command,
    input  logic [7:0]         position,
    input  logic signed [31:0] value,
    output logic               done,
    output logic               ok,
    output logic [7:0]         found_position,
    output logic signed [31:0] read_value,
    output logic [7:0]         length,
    output logic               is_full,
    output logic               is_empty
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 8) ? CW : 8;

    logic [31:0] mem [CAPACITY];
    logic [31:0] q_reg;

    psl_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [AW-1:0] src_reg, src_next;
    logic [AW-1:0] dst_reg, dst_next;
    logic          pend_reg, pend_next;
    logic [2:0]    cmd_reg, cmd_next;
    logic [7:0]    pos_reg, pos_next;
    logic [31:0]   val_reg, val_next;

    logic          done_reg, done_next;
    logic          ok_reg, ok_next;
    logic [7:0]    found_reg, found_next;
    logic [31:0]   rdv_reg, rdv_next;
    logic [7:0]    length_reg, length_next;
    logic          full_reg, full_next;
    logic          empty_reg, empty_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;

    logic          fin;
    logic          fin_ok;
    logic [7:0]    fin_found;
    logic [31:0]   fin_rd;

    logic [XW-1:0] pos_x, cnt_x, posr_x, tag_x, len_x;
    logic          pos_valid, ins_valid;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        q_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psl_pkg::S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        src_reg    <= src_next;
        dst_reg    <= dst_next;
        cmd_reg    <= cmd_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        ok_reg     <= ok_next;
        found_reg  <= found_next;
        rdv_reg    <= rdv_next;
        length_reg <= length_next;
        full_reg   <= full_next;
        empty_reg  <= empty_next;
    end

    assign pos_x     = XW'(position);
    assign posr_x    = XW'(pos_reg);
    assign cnt_x     = XW'(count_reg);
    assign tag_x     = XW'(dst_reg) + XW'(1);
    assign pos_valid = (pos_x != '0) && (pos_x <= cnt_x);
    assign ins_valid = (pos_x != '0) && (pos_x <= cnt_x + XW'(1))
                       && (count_reg < CW'(CAPACITY));

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        rem_next    = rem_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        pend_next   = pend_reg;
        cmd_next    = cmd_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        done_next   = 1'b0;
        ok_next     = ok_reg;
        found_next  = found_reg;
        rdv_next    = rdv_reg;
        length_next = length_reg;
        full_next   = full_reg;
        empty_next  = empty_reg;

        mem_we    = 1'b0;
        mem_waddr = dst_reg;
        mem_wdata = q_reg;
        mem_raddr = src_reg;

        fin       = 1'b0;
        fin_ok    = 1'b0;
        fin_found = '0;
        fin_rd    = '0;

        unique case (state_reg)
            psl_pkg::S_IDLE:
            begin
                mem_raddr = AW'(pos_x - XW'(1));
                if (start)
                begin
                    cmd_next = command;
                    pos_next = position;
                    val_next = value;
                    unique case (command) inside
                        psl_pkg::CMD_SEARCH:
                        begin
                            src_next   = '0;
                            rem_next   = count_reg;
                            pend_next  = 1'b0;
                            state_next = psl_pkg::S_SCAN;
                        end
                        psl_pkg::CMD_GET, psl_pkg::CMD_REMOVE:
                        begin
                            if (pos_valid)
                            begin
                                state_next = psl_pkg::S_TAKE;
                            end
                            else
                            begin
                                fin = 1'b1;
                            end
                        end
                        psl_pkg::CMD_LOCATE:
                        begin
                            fin       = 1'b1;
                            fin_ok    = pos_valid;
                            fin_found = pos_valid ? position : 8'd0;
                        end
                        psl_pkg::CMD_SET:
                        begin
                            fin    = 1'b1;
                            fin_ok = pos_valid;
                            if (pos_valid)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(pos_x - XW'(1));
                                mem_wdata = value;
                            end
                        end
                        psl_pkg::CMD_INSERT:
                        begin
                            if (ins_valid)
                            begin
                                // move entries count-1 down to pos-1 up by one
                                src_next   = AW'(cnt_x - XW'(1));
                                rem_next   = CW'(cnt_x - pos_x + XW'(1));
                                pend_next  = 1'b0;
                                state_next = psl_pkg::S_SHIFT;
                            end
                            else
                            begin
                                fin = 1'b1;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            psl_pkg::S_SCAN:
            begin
                if (pend_reg && (q_reg == val_reg))
                begin
                    fin       = 1'b1;
                    fin_ok    = 1'b1;
                    fin_found = tag_x[7:0];
                    pend_next = 1'b0;
                end
                else
                begin
                    pend_next = (rem_reg != '0);
                    if (rem_reg != '0)
                    begin
                        src_next = src_reg + AW'(1);
                        rem_next = rem_reg - CW'(1);
                        dst_next = src_reg;
                    end
                    else if (!pend_reg)
                    begin
                        fin = 1'b1;
                    end
                end
            end

            psl_pkg::S_TAKE:
            begin
                if (cmd_reg == psl_pkg::CMD_GET)
                begin
                    fin    = 1'b1;
                    fin_ok = 1'b1;
                    fin_rd = q_reg;
                end
                else
                begin
                    // hold the removed entry, then pull pos..count-1 down by one
                    val_next   = q_reg;
                    src_next   = AW'(posr_x);
                    rem_next   = CW'(cnt_x - posr_x);
                    pend_next  = 1'b0;
                    state_next = psl_pkg::S_SHIFT;
                end
            end

            psl_pkg::S_SHIFT:
            begin
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = dst_reg;
                    mem_wdata = q_reg;
                end
                pend_next = (rem_reg != '0);
                if (rem_reg != '0)
                begin
                    rem_next = rem_reg - CW'(1);
                    if (cmd_reg == psl_pkg::CMD_INSERT)
                    begin
                        src_next = src_reg - AW'(1);
                        dst_next = src_reg + AW'(1);
                    end
                    else
                    begin
                        src_next = src_reg + AW'(1);
                        dst_next = src_reg - AW'(1);
                    end
                end
                else if (!pend_reg)
                begin
                    fin    = 1'b1;
                    fin_ok = 1'b1;
                    if (cmd_reg == psl_pkg::CMD_INSERT)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = AW'(posr_x - XW'(1));
                        mem_wdata  = val_reg;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        fin_rd     = val_reg;
                        count_next = count_reg - CW'(1);
                    end
                end
            end

            default:
            begin
                state_next = psl_pkg::S_IDLE;
            end
        endcase

        len_x = XW'(count_next);
        if (fin)
        begin
            state_next  = psl_pkg::S_IDLE;
            done_next   = 1'b1;
            ok_next     = fin_ok;
            found_next  = fin_found;
            rdv_next    = fin_rd;
            length_next = len_x[7:0];
            full_next   = (count_next == CW'(CAPACITY));
            empty_next  = (count_next == '0);
        end
    end

    assign busy           = (state_reg != psl_pkg::S_IDLE);
    assign done           = done_reg;
    assign ok             = ok_reg;
    assign found_position = found_reg;
    assign read_value     = $signed(rdv_reg);
    assign length         = length_reg;
    assign is_full        = full_reg;
    assign is_empty       = empty_reg;

endmodule

[rtl/psl_checker.sv]
// psl_checker: port-level assertions for positional_sequence_list_unit
// bound to the top level below; uses no package items
module psl_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic               ok,
    input logic [7:0]         found_position,
    input logic signed [31:0] read_value,
    input logic               is_full,
    input logic               is_empty
);

    // every accepted transaction either finishes at once or holds busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted transaction neither finished nor busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a start");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (found_position == 8'd0 && read_value == 32'sd0))
        else $error("failed transaction carries data");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(is_full && is_empty))
        else $error("full and empty together");

endmodule

bind positional_sequence_list_unit psl_checker u_psl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .ok             (ok),
    .found_position (found_position),
    .read_value     (read_value),
    .is_full        (is_full),
    .is_empty       (is_empty)
);
